[rtl/srv_pkg.sv]
// Shared types and constants for the stored record validator.
`default_nettype none

package srv_pkg;

    // Record layout and CRC-32 constants.
    localparam int          HDR_BYTES = 16;
    localparam logic [31:0] REC_MAGIC = 32'h5453_5250;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int SIZE_W      = 12;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_EXPECTED_VERSION = 2'd0,
        CFG_REGION_MAX       = 2'd1,
        CFG_CALLER_CAPACITY  = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_LOADED        = 3'd0,
        ST_BAD_MAGIC     = 3'd1,
        ST_VERSION       = 3'd2,
        ST_BAD_SIZE      = 3'd3,
        ST_TOO_SMALL     = 3'd4,
        ST_CRC_MISMATCH  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef struct packed {
        logic [15:0]       expected_version;
        logic [SIZE_W-1:0] region_max_payload;
        logic [SIZE_W-1:0] caller_capacity;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        status_t           status;
        logic [SIZE_W-1:0] size;
    } result_t;

endpackage

`default_nettype wire

[rtl/srv_crc_byte.sv]
// One byte of reflected CRC-32, eight bit steps unrolled.
`default_nettype none

module srv_crc_byte
    import srv_pkg::*;
(
    input  wire logic [31:0] crc_in,
    input  wire logic [7:0]  data,
    output logic      [31:0] crc_out
);

    always_comb
    begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

[rtl/srv_core.sv]
// Record parser: header capture, early checks and payload CRC tracking.
`default_nettype none

module srv_core
    import srv_pkg::*;
#(
    parameter int REGION_BYTES = 4096
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire logic       record_start,
    input  wire cfg_t       cfg,
    output result_t         res
);

    // Largest size the region itself allows, after the header.
    localparam logic [15:0] SIZE_LIMIT = 16'(REGION_BYTES - HDR_BYTES);

    phase_t             phase_reg, phase_next;
    logic [SIZE_W-1:0]  count_reg, count_next;
    logic [23:0]        magic_reg, magic_next;
    logic [7:0]         ver_lo_reg, ver_lo_next;
    logic [23:0]        size_bytes_reg, size_bytes_next;
    logic [31:0]        hdr_crc_reg, hdr_crc_next;
    logic [31:0]        crc_reg, crc_next;
    logic [SIZE_W-1:0]  pay_size_reg, pay_size_next;
    logic [31:0]        crc_step;

    srv_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data    (data_byte),
        .crc_out (crc_step)
    );

    always_comb
    begin
        phase_t      eff_phase;
        logic [3:0]  idx;
        logic [15:0] size16;
        logic        size_hi;

        phase_next      = phase_reg;
        count_next      = count_reg;
        magic_next      = magic_reg;
        ver_lo_next     = ver_lo_reg;
        size_bytes_next = size_bytes_reg;
        hdr_crc_next    = hdr_crc_reg;
        crc_next        = crc_reg;
        pay_size_next   = pay_size_reg;
        res.valid       = 1'b0;
        res.status      = ST_LOADED;
        res.size        = '0;

        // A record start restarts the header at the current byte.
        eff_phase = record_start ? PH_HEADER : phase_reg;
        idx       = record_start ? 4'd0 : count_reg[3:0];
        size16    = size_bytes_reg[15:0];
        size_hi   = (data_byte != 8'd0) || (size_bytes_reg[23:16] != 8'd0);

        if (step)
        begin
            case (eff_phase)
                PH_HEADER:
                begin
                    phase_next = PH_HEADER;
                    count_next = {{(SIZE_W-4){1'b0}}, idx + 4'd1};
                    case (idx)
                        4'd0: magic_next[7:0]   = data_byte;
                        4'd1: magic_next[15:8]  = data_byte;
                        4'd2: magic_next[23:16] = data_byte;
                        4'd3:
                        begin
                            if ({data_byte, magic_reg} != REC_MAGIC)
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_BAD_MAGIC;
                                phase_next = PH_IDLE;
                            end
                        end
                        4'd4: ver_lo_next = data_byte;
                        4'd5:
                        begin
                            if ({data_byte, ver_lo_reg} != cfg.expected_version)
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_VERSION;
                                phase_next = PH_IDLE;
                            end
                        end
                        4'd8:  size_bytes_next[7:0]   = data_byte;
                        4'd9:  size_bytes_next[15:8]  = data_byte;
                        4'd10: size_bytes_next[23:16] = data_byte;
                        4'd11:
                        begin
                            // The upper two size bytes must be zero for any legal size.
                            if (size_hi || size16 == 16'd0
                                || size16 > {4'd0, cfg.region_max_payload}
                                || size16 > SIZE_LIMIT)
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_BAD_SIZE;
                                phase_next = PH_IDLE;
                            end
                            else if (size16 > {4'd0, cfg.caller_capacity})
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_TOO_SMALL;
                                phase_next = PH_IDLE;
                            end
                            pay_size_next = size16[SIZE_W-1:0];
                        end
                        4'd12: hdr_crc_next[7:0]   = data_byte;
                        4'd13: hdr_crc_next[15:8]  = data_byte;
                        4'd14: hdr_crc_next[23:16] = data_byte;
                        4'd15:
                        begin
                            hdr_crc_next[31:24] = data_byte;
                            phase_next          = PH_PAYLOAD;
                            count_next          = '0;
                            crc_next            = CRC_INIT;
                        end
                        default:
                        begin
                            // Reserved header bytes carry nothing we check.
                        end
                    endcase
                end
                PH_PAYLOAD:
                begin
                    crc_next   = crc_step;
                    count_next = count_reg + {{(SIZE_W-1){1'b0}}, 1'b1};
                    if (count_next >= pay_size_reg)
                    begin
                        res.valid  = 1'b1;
                        phase_next = PH_IDLE;
                        if (~crc_step != hdr_crc_reg)
                        begin
                            res.status = ST_CRC_MISMATCH;
                        end
                        else
                        begin
                            res.status = ST_LOADED;
                            res.size   = pay_size_reg;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        magic_reg      <= magic_next;
        ver_lo_reg     <= ver_lo_next;
        size_bytes_reg <= size_bytes_next;
        hdr_crc_reg    <= hdr_crc_next;
        crc_reg        <= crc_next;
        pay_size_reg   <= pay_size_next;
    end

endmodule

`default_nettype wire

[rtl/stored_record_validator_top.sv]
// Top level of the stored record validator: ports, configuration and word registers.
`default_nettype none

// The validator takes a stored record image one byte word per cycle, with
// record_start marking the first byte of a 16-byte little-endian header
// (magic, version, reserved, payload size, CRC-32). It reports one result
// word per record as soon as the outcome is known: a bad magic on header
// byte 3, a version mismatch on byte 5, a bad size or too small a buffer on
// byte 11, and otherwise a CRC check result after the last payload byte.
// Bytes outside a record are dropped, and a new record_start abandons the
// record in progress without a result. Each byte word goes through an input
// register, header decode and CRC update (a byte-wide CRC-32 step with all
// eight bit steps unrolled), and into a result register, so the block
// sustains one byte word per clock; the result word is registered in the
// result register after the deciding byte word has passed the input
// register. It only stalls input while a result word sits in the output
// register and the downstream side stalls it.
// Configuration writes take effect on the next clock and are expected only
// while no record is in flight.

module stored_record_validator_top
    import srv_pkg::*;
#(
    parameter int REGION_BYTES = 4096
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                   byte_valid,
    output logic                        byte_stall,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   record_start,

    output logic                        result_valid,
    input  wire logic                   result_stall,
    output logic [2:0]                  status,
    output logic [SIZE_W-1:0]           payload_size
);

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_start_reg;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg;
    logic [SIZE_W-1:0] out_size_reg;
    logic              advance;
    result_t           res;

    // The staged word moves on whenever the result register is free or
    // is being emptied this cycle; every word makes at most one result.
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign byte_stall = in_valid_reg && !advance;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_version   <= 16'd0;
            cfg_reg.region_max_payload <= 12'd2032;
            cfg_reg.caller_capacity    <= 12'd4080;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_EXPECTED_VERSION: cfg_reg.expected_version   <= cfg_data;
                CFG_REGION_MAX:       cfg_reg.region_max_payload <= cfg_data[SIZE_W-1:0];
                CFG_CALLER_CAPACITY:  cfg_reg.caller_capacity    <= cfg_data[SIZE_W-1:0];
                default:
                begin
                    // Unused index: the write is dropped.
                end
            endcase
        end
    end

    // Input word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_byte_reg  <= data_byte;
            in_start_reg <= record_start;
        end
    end

    srv_core #(
        .REGION_BYTES (REGION_BYTES)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .data_byte    (in_byte_reg),
        .record_start (in_start_reg),
        .cfg          (cfg_reg),
        .res          (res)
    );

    // Result word register.
    always_comb
    begin
        out_valid_next = out_valid_reg && result_stall;
        if (advance && res.valid)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            out_status_reg <= res.status;
            out_size_reg   <= res.size;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign payload_size = out_size_reg;

endmodule

`default_nettype wire

[rtl/srv_checker.sv]
// Port-level assertions for the stored record validator, bound to the top level.
`default_nettype none

module srv_checker
    import srv_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              byte_stall,
    input wire logic              result_valid,
    input wire logic              result_stall,
    input wire logic [2:0]        status,
    input wire logic [SIZE_W-1:0] payload_size
);

    // A stalled result word stays put.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(status)
            && $stable(payload_size))
        else $error("stalled result word changed");

    // Input only backs up behind a stalled result word.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> result_valid && result_stall)
        else $error("input stalled without a pending result");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> status == ST_LOADED || status == ST_BAD_MAGIC
            || status == ST_VERSION || status == ST_BAD_SIZE
            || status == ST_TOO_SMALL || status == ST_CRC_MISMATCH)
        else $error("status code out of range");

    // Only a loaded record carries a size, and that size is never zero.
    a_size_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != ST_LOADED |-> payload_size == '0)
        else $error("size reported with a failure status");

    a_size_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_LOADED |-> payload_size != '0)
        else $error("loaded record with zero size");

endmodule

bind stored_record_validator_top srv_checker u_srv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_stall   (byte_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .payload_size (payload_size)
);

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for the stored record validator: random record streams against a predictor.
module tb;
    import srv_pkg::*;

    localparam int REGION_BYTES   = 4096;
    localparam int SIZE_CEILING   = REGION_BYTES - HDR_BYTES;
    localparam int HALF_PERIOD    = 5;
    localparam int TIMEOUT_CYCLES = 800_000;
    // The block passes the byte that decides a result through its input and
    // result registers, so these quiet cycles are plenty before touching the registers.
    localparam int SETTLE         = 12;
    localparam int LONG_HOLD      = 200;
    localparam int SMALL_SIZE     = 24;
    localparam int PHASE_BYTES    = 90;

    // How a side spaces its words: never idle, a random pause before every word,
    // or mostly back to back with an occasional pause.
    typedef enum int {PACE_NONE, PACE_FULL, PACE_SPARSE} pace_t;

    typedef struct {
        status_t           status;
        logic [SIZE_W-1:0] size;
    } verdict_t;

    // Tracks the header parse and payload CRC of the block from the accepted
    // byte words and keeps the verdicts it has worked out in arrival order.
    class verdict_board;
        logic [15:0]       want_version;
        logic [SIZE_W-1:0] region_max;
        logic [SIZE_W-1:0] capacity;
        phase_t            stage;
        logic [12:0]       count;
        logic [31:0]       magic;
        logic [15:0]       version;
        logic [31:0]       size;
        logic [31:0]       stored_crc;
        logic [31:0]       running_crc;
        verdict_t          pending[$];
        int                errors;
        int                checked;
        int                per_status[8];

        function new();
            want_version = '0;
            region_max   = 12'd2032;
            capacity     = 12'd4080;
            stage        = PH_IDLE;
            count        = '0;
            magic        = '0;
            version      = '0;
            size         = '0;
            stored_crc   = '0;
            running_crc  = CRC_INIT;
            errors       = 0;
            checked      = 0;
            foreach (per_status[k])
                per_status[k] = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_EXPECTED_VERSION: want_version = val;
                CFG_REGION_MAX:       region_max   = val[SIZE_W-1:0];
                CFG_CALLER_CAPACITY:  capacity     = val[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // One byte of the reflected CRC-32, LSB first.
        static function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
            crc = crc ^ {24'd0, b};
            for (int k = 0; k < 8; k++)
                crc = (crc >> 1) ^ (CRC_POLY & {32{crc[0]}});
            return crc;
        endfunction

        function void decide(status_t st, logic [31:0] sz);
            verdict_t v;
            v.status = st;
            v.size   = (st == ST_LOADED) ? sz[SIZE_W-1:0] : '0;
            pending.push_back(v);
            stage = PH_IDLE;
        endfunction

        function void take_byte(logic [7:0] b, logic start);
            logic [3:0] idx;
            if (start)
            begin
                stage       = PH_HEADER;
                count       = '0;
                magic       = '0;
                version     = '0;
                size        = '0;
                stored_crc  = '0;
                running_crc = CRC_INIT;
            end
            if (stage == PH_HEADER)
            begin
                idx = count[3:0];
                if (idx < 4)
                    magic = magic | (32'(b) << (8 * idx[1:0]));
                else if (idx < 6)
                    version = version | (16'(b) << (8 * idx[0]));
                else if (idx >= 8 && idx < 12)
                    size = size | (32'(b) << (8 * idx[1:0]));
                else if (idx >= 12)
                    stored_crc = stored_crc | (32'(b) << (8 * idx[1:0]));
                count = count + 13'd1;
                if (idx == 3 && magic != REC_MAGIC)
                    decide(ST_BAD_MAGIC, '0);
                else if (idx == 5 && version != want_version)
                    decide(ST_VERSION, '0);
                else if (idx == 11 && (size == 0 || size > 32'(region_max) ||
                                       size > 32'(SIZE_CEILING)))
                    decide(ST_BAD_SIZE, '0);
                else if (idx == 11 && size > 32'(capacity))
                    decide(ST_TOO_SMALL, '0);
                else if (idx == 15)
                begin
                    stage       = PH_PAYLOAD;
                    count       = '0;
                    running_crc = CRC_INIT;
                end
            end
            else if (stage == PH_PAYLOAD)
            begin
                running_crc = crc_step(running_crc, b);
                count       = count + 13'd1;
                if (32'(count) >= size)
                begin
                    if (~running_crc != stored_crc)
                        decide(ST_CRC_MISMATCH, '0);
                    else
                        decide(ST_LOADED, size);
                end
            end
            else
                stage = PH_IDLE;
        endfunction

        function void match_verdict(logic [2:0] st, logic [SIZE_W-1:0] sz);
            verdict_t v;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: result word with none expected: status %0d size %0d",
                         $time, st, sz);
                return;
            end
            v = pending.pop_front();
            checked++;
            per_status[st]++;
            if (st !== v.status)
            begin
                errors++;
                $display("%0t: status expected %0d, got %0d", $time, v.status, st);
            end
            if (sz !== v.size)
            begin
                errors++;
                $display("%0t: payload_size expected %0d, got %0d", $time, v.size, sz);
            end
        endfunction
    endclass

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_write    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   byte_valid   = 1'b0;
    logic                   byte_stall;
    logic [7:0]             data_byte    = '0;
    logic                   record_start = 1'b0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic [2:0]             status;
    logic [SIZE_W-1:0]      payload_size;

    verdict_board board = new();

    pace_t src_pace      = PACE_FULL;
    pace_t sink_pace     = PACE_FULL;
    bit    long_hold     = 1'b0;
    int    bytes_sent    = 0;
    int    settings_used = 0;

    stored_record_validator_top #(.REGION_BYTES(REGION_BYTES)) dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .record_start (record_start),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .payload_size (payload_size)
    );

    always #HALF_PERIOD clk = ~clk;

    // Both handshakes are observed at the rising edge, where inputs driven at
    // the falling edge have long settled and the block's own updates are not
    // yet visible.
    always @(posedge clk)
    begin
        if (rst_n && byte_valid && !byte_stall)
            board.take_byte(data_byte, record_start);
        if (rst_n && result_valid && !result_stall)
            board.match_verdict(status, payload_size);
    end

    function automatic int draw_gap(pace_t pace);
        case (pace)
            PACE_NONE: return 0;
            PACE_FULL: return $urandom_range(0, 11);
            default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 11) : 0;
        endcase
    endfunction

    // Offers one byte word after a random pause and holds it until taken.
    // With no pause, valid simply stays high and only the payload moves on.
    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = draw_gap(src_pace);
        @(negedge clk);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid   <= 1'b1;
        data_byte    <= b;
        record_start <= start;
        do
            @(posedge clk);
        while (!(byte_valid && !byte_stall));
        bytes_sent++;
    endtask

    // Sends the first cut bytes of a header built from the given fields; with
    // a whole header the body follows. The stored CRC covers the first
    // size_field body bytes, or all of them when the body is shorter.
    task automatic send_record(input logic [31:0] magic, input logic [15:0] ver,
                               input logic [31:0] size_field, input int body_len,
                               input int cut, input bit spoil);
        logic [7:0]  head [16];
        logic [7:0]  body [];
        logic [31:0] crc;
        int          k;
        body = new[body_len];
        foreach (body[j])
            body[j] = 8'($urandom);
        crc = CRC_INIT;
        for (k = 0; k < body_len && 32'(k) < size_field; k++)
            crc = verdict_board::crc_step(crc, body[k]);
        crc = ~crc;
        if (spoil)
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
        for (k = 0; k < 4; k++)
        begin
            head[k]      = magic[8*k +: 8];
            head[8 + k]  = size_field[8*k +: 8];
            head[12 + k] = crc[8*k +: 8];
        end
        head[4] = ver[7:0];
        head[5] = ver[15:8];
        head[6] = 8'($urandom);
        head[7] = 8'($urandom);
        for (k = 0; k < cut; k++)
            send_byte(head[k], k == 0);
        if (cut == HDR_BYTES)
            foreach (body[j])
                send_byte(body[j], 1'b0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        board.set_reg(idx, val);
    endtask

    task automatic apply_settings(input logic [15:0] ver, input logic [SIZE_W-1:0] region,
                                  input logic [SIZE_W-1:0] cap);
        write_reg(CFG_EXPECTED_VERSION, ver);
        write_reg(CFG_REGION_MAX, CFG_DATA_W'(region));
        write_reg(CFG_CALLER_CAPACITY, CFG_DATA_W'(cap));
        @(negedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // Drops valid, waits for every outstanding verdict, then lets the
    // pipeline run dry so nothing is in flight for a register write.
    task automatic quiesce();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Short payloads of at least one byte, never above a limit of one or more.
    function automatic logic [31:0] good_size(int limit);
        if (limit < 1)
            return 32'd1;
        return 32'($urandom_range(1, (limit < SMALL_SIZE) ? limit : SMALL_SIZE));
    endfunction

    function automatic logic [31:0] bad_size();
        int region;
        region = board.region_max;
        case ($urandom_range(0, 3))
            0: return '0;
            1:
            begin
                if (region < 4095)
                    return 32'($urandom_range(region + 1, 4095));
                return 32'($urandom_range(SIZE_CEILING + 1, 4095));
            end
            2: return 32'($urandom_range(SIZE_CEILING + 1, 4095));
            default: return 32'($urandom) | 32'h0000_1000;
        endcase
    endfunction

    // One random record. About half reach the payload CRC, well formed or with a
    // spoiled CRC; the rest fail at each header check, get cut short and
    // abandoned by the next start, or are loose noise bytes.
    task automatic random_record();
        int          pick;
        int          limit;
        int          upper;
        logic [31:0] sz;
        logic [15:0] ver;
        logic [31:0] magic;
        ver   = board.want_version;
        limit = board.region_max;
        if (board.capacity < limit)
            limit = board.capacity;
        if (SIZE_CEILING < limit)
            limit = SIZE_CEILING;
        if ($urandom_range(0, 5) == 0)
            src_pace = pace_t'($urandom_range(0, 2));
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            // Valid record, sometimes with trailing bytes the block must drop.
            sz = good_size(limit);
            send_record(REC_MAGIC, ver, sz,
                        sz + (($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0),
                        HDR_BYTES, 1'b0);
        end
        else if (pick < 50)
        begin
            sz = good_size(limit);
            send_record(REC_MAGIC, ver, sz, sz, HDR_BYTES, 1'b1);
        end
        else if (pick < 58)
        begin
            if ($urandom_range(0, 1) == 0)
                magic = 32'($urandom);
            else
                magic = REC_MAGIC ^ (32'd1 << $urandom_range(0, 31));
            send_record(magic, ver, 32'($urandom), 0,
                        ($urandom_range(0, 1) == 0) ? 4 : HDR_BYTES, 1'b0);
        end
        else if (pick < 66)
        begin
            send_record(REC_MAGIC, ver ^ (16'd1 << $urandom_range(0, 15)), 32'($urandom), 0,
                        ($urandom_range(0, 1) == 0) ? 6 : HDR_BYTES, 1'b0);
        end
        else if (pick < 76)
        begin
            send_record(REC_MAGIC, ver, bad_size(), 0,
                        ($urandom_range(0, 1) == 0) ? 12 : HDR_BYTES, 1'b0);
        end
        else if (pick < 84)
        begin
            // Size legal for the region but above the caller's buffer if room, else a bad size.
            upper = board.region_max;
            if (upper > SIZE_CEILING)
                upper = SIZE_CEILING;
            if (int'(board.capacity) < upper)
                sz = 32'($urandom_range(board.capacity + 1, upper));
            else
                sz = bad_size();
            send_record(REC_MAGIC, ver, sz, 0,
                        ($urandom_range(0, 1) == 0) ? 12 : HDR_BYTES, 1'b0);
        end
        else if (pick < 92)
        begin
            // Broken off: the next record start abandons it without a result.
            sz = good_size(limit);
            if ($urandom_range(0, 1) == 0)
                send_record(REC_MAGIC, ver, sz, $urandom_range(0, sz - 1), HDR_BYTES, 1'b0);
            else
                send_record(REC_MAGIC, ver, sz, 0, $urandom_range(1, 15), 1'b0);
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end
    endtask

    // Result side. Before each result word it may hold stall high for a
    // random number of cycles counted from the word's arrival. On request it
    // holds off for a long fixed stretch so the block backs up into its input.
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
                result_stall <= 1'b0;
            end
            else
            begin
                gap = draw_gap(sink_pace);
                if (gap > 0)
                begin
                    result_stall <= 1'b1;
                    while (!result_valid)
                        @(negedge clk);
                    repeat (gap) @(negedge clk);
                end
                result_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(result_valid && !result_stall) && !long_hold);
            if ($urandom_range(0, 7) == 0)
                sink_pace = pace_t'($urandom_range(0, 2));
        end
    end

    initial
    begin
        int               setting;
        int               mark;
        logic [SIZE_W-1:0] region;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening under the reset register values: an all-ones byte
        // outside any record, a record start abandoned after two bytes, a bad
        // magic made of zero bytes, a version mismatch, and a one-byte record
        // that loads.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h50, 1'b1);
        send_byte(8'h52, 1'b0);
        send_record(32'h0, 16'h0, 32'h0, 0, 4, 1'b0);
        send_record(REC_MAGIC, 16'hFFFF, 32'd1, 0, 6, 1'b0);
        send_record(REC_MAGIC, board.want_version, 32'd1, 1, HDR_BYTES, 1'b0);
        quiesce();

        for (setting = 0; setting < 6; setting++)
        begin
            case (setting)
                0: apply_settings(16'h0000, 12'hFFF, 12'hFFF);
                1: apply_settings(16'hFFFF, 12'd1, 12'd0);
                2: apply_settings(16'($urandom), 12'd2032, 12'd4080);
                3:
                begin
                    region = 12'($urandom_range(16, 64));
                    apply_settings(16'($urandom), region, 12'($urandom_range(0, region)));
                end
                4: apply_settings(16'hA55A, 12'd4080, 12'd4080);
                default: apply_settings(16'($urandom), 12'($urandom_range(1, 4095)),
                                        12'($urandom_range(0, 4095)));
            endcase

            if (setting == 0)
            begin
                // The widest region admits a full 4080-byte payload: its size
                // passes every header check, and the next record start then
                // abandons it without a result.
                send_record(REC_MAGIC, board.want_version, 32'(SIZE_CEILING), 0,
                            12, 1'b0);
            end
            if (setting == 4)
            begin
                // Back-to-back short failures while the result side holds off,
                // so the output register fills and the input stalls.
                long_hold = 1'b1;
                src_pace  = PACE_NONE;
                repeat (30)
                    send_record(32'h0, 16'h0, 32'h0, 0, 4, 1'b0);
            end

            mark = bytes_sent;
            while (bytes_sent - mark < PHASE_BYTES ||
                   (setting == 5 && (bytes_sent < 720 ||
                                     board.checked + board.pending.size() < 60)))
                random_record();
            // Close on a record that decides, so the block is idle afterwards.
            send_record(32'h0, 16'h0, 32'h0, 0, 4, 1'b0);
            quiesce();
        end

        $display("tb: %0d byte words sent under %0d register settings, %0d result words checked",
                 bytes_sent, settings_used, board.checked);
        $display("tb: loaded %0d, bad magic %0d, version %0d, bad size %0d, too small %0d, crc %0d",
                 board.per_status[ST_LOADED], board.per_status[ST_BAD_MAGIC],
                 board.per_status[ST_VERSION], board.per_status[ST_BAD_SIZE],
                 board.per_status[ST_TOO_SMALL], board.per_status[ST_CRC_MISMATCH]);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Many times the slowest legal run with the longest pauses on both sides.
    initial
    begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("tb: failure");
        $finish;
    end

endmodule
